/* hw/rtl/lts_pkg.sv */
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the token scanner
// Scan modes, character codes and the token record that travels through
// the result queue.
// ----------------------------------------------------------------------------
package lts_pkg;

    localparam int unsigned MAX_TEXT_DEFAULT = 65536;
    localparam int unsigned POS_W            = 17;
    localparam int unsigned START_W          = 16;
    localparam int unsigned LEN_W            = 17;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SYMBOL  = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_COMMENT = 3'd4
    } scan_mode_t;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_VTAB      = 8'h0B;
    localparam logic [7:0] CH_FORMFEED  = 8'h0C;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_BACKTICK  = 8'h60;
    localparam logic [7:0] CH_CARET     = 8'h5E;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SEMICOLON = 8'h3B;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               end_tok;
        logic               unterm;
        logic               last;
    } token_t;

    function automatic logic is_separator(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
               c == CH_FORMFEED || c == CH_RETURN || c == CH_COMMA;
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return c == CH_LBRACKET || c == CH_RBRACKET || c == CH_LBRACE ||
               c == CH_RBRACE || c == CH_LPAREN || c == CH_RPAREN ||
               c == CH_APOS || c == CH_BACKTICK || c == CH_CARET || c == CH_AT;
    endfunction

endpackage

/* hw/rtl/lisp_token_scanner_top.sv */
// ----------------------------------------------------------------------------
// lisp_token_scanner_top: s-expression token scanner
// Usage:
//   Input channel (in_valid / in_stall): one source character per beat in
//   ch, or a beat with end_of_text set that closes the text.
//   Output channel (out_valid / out_stall): one token record per beat,
//   token_start and token_length, with end_token on the closing record
//   and last_result on the final record caused by an input beat.
//   An input beat is classified and the scan mode updated in the cycle it
//   is taken; its records are registered into a four-entry result queue,
//   whose head record drives the output. A character beat gives zero, one
//   or two records, the end beat one or two.
//   Throughput is one input beat per cycle while the queue drains at least
//   as fast as it fills; in_stall rises whenever the queue has fewer than
//   two free entries, so a beat giving two records leaves one per output beat.
//   A stalled receiver holds the head record steady and backs up the input.
//   Reset empties the queue and returns to the idle mode at offset zero;
//   after the end token the scanner returns to the same state.
//   Characters at or beyond the text limit are dropped without effect.
// ----------------------------------------------------------------------------
module lisp_token_scanner_top #(
    parameter int unsigned MAX_TEXT = lts_pkg::MAX_TEXT_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   ch,
    input  logic                         end_of_text,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [lts_pkg::START_W-1:0]  token_start,
    output logic [lts_pkg::LEN_W-1:0]    token_length,
    output logic                         end_token,
    output logic                         unterminated_string,
    output logic                         last_result
);

    localparam int unsigned TEXT_LIMIT = (MAX_TEXT < 65536) ? MAX_TEXT : 65536;
    localparam int unsigned QDEPTH     = 4;
    localparam int unsigned QPTR_W     = $clog2(QDEPTH);
    localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

    lts_pkg::scan_mode_t                 mode_reg, mode_next;
    logic [lts_pkg::START_W-1:0]         begin_reg, begin_next;
    logic [lts_pkg::POS_W-1:0]           pos_reg, pos_next;

    lts_pkg::token_t                     queue_mem [QDEPTH];
    logic [QPTR_W-1:0]                   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]                   count_reg;

    lts_pkg::token_t                     res0, res1;
    logic [1:0]                          res_count;
    logic                                in_take, out_take;
    logic [lts_pkg::LEN_W-1:0]           open_len, string_len;
    logic                                at_limit;

    assign in_stall  = count_reg > QCNT_W'(QDEPTH - 2);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = count_reg != '0;
    assign out_take  = out_valid && !out_stall;

    assign open_len   = pos_reg - {1'b0, begin_reg};
    assign string_len = pos_reg + 17'd1 - {1'b0, begin_reg};
    assign at_limit   = pos_reg >= lts_pkg::POS_W'(TEXT_LIMIT);

    always_comb
    begin
        mode_next  = mode_reg;
        begin_next = begin_reg;
        pos_next   = pos_reg;
        res0       = '0;
        res1       = '0;
        res_count  = 2'd0;

        if (end_of_text)
        begin
            // close any open symbol, then the end marker
            res1.end_tok = 1'b1;
            res1.last    = 1'b1;
            res1.unterm  = (mode_reg == lts_pkg::MODE_STRING) ||
                           (mode_reg == lts_pkg::MODE_ESCAPE);
            if (mode_reg == lts_pkg::MODE_SYMBOL)
            begin
                res0.start  = begin_reg;
                res0.length = open_len;
                res_count   = 2'd2;
            end
            else
            begin
                res0      = res1;
                res_count = 2'd1;
            end
            mode_next  = lts_pkg::MODE_IDLE;
            begin_next = '0;
            pos_next   = '0;
        end
        else if (!at_limit)
        begin
            pos_next = pos_reg + 17'd1;
            unique case (mode_reg)
                lts_pkg::MODE_SYMBOL:
                begin
                    res0.start  = begin_reg;
                    res0.length = open_len;
                    res1.start  = pos_reg[lts_pkg::START_W-1:0];
                    res1.length = 17'd1;
                    res1.last   = 1'b1;
                    if (lts_pkg::is_separator(ch))
                    begin
                        res0.last = 1'b1;
                        res_count = 2'd1;
                        mode_next = lts_pkg::MODE_IDLE;
                    end
                    else if (lts_pkg::is_single(ch))
                    begin
                        res_count = 2'd2;
                        mode_next = lts_pkg::MODE_IDLE;
                    end
                end
                lts_pkg::MODE_STRING:
                begin
                    if (ch == lts_pkg::CH_BACKSLASH)
                    begin
                        mode_next = lts_pkg::MODE_ESCAPE;
                    end
                    else if (ch == lts_pkg::CH_DQUOTE)
                    begin
                        res0.start  = begin_reg;
                        res0.length = string_len;
                        res0.last   = 1'b1;
                        res_count   = 2'd1;
                        mode_next   = lts_pkg::MODE_IDLE;
                    end
                end
                lts_pkg::MODE_ESCAPE:
                begin
                    mode_next = lts_pkg::MODE_STRING;
                end
                lts_pkg::MODE_COMMENT:
                begin
                    if (ch == lts_pkg::CH_NEWLINE)
                        mode_next = lts_pkg::MODE_IDLE;
                end
                default:
                begin
                    mode_next = lts_pkg::MODE_IDLE;
                    if (lts_pkg::is_separator(ch))
                    begin
                        mode_next = lts_pkg::MODE_IDLE;
                    end
                    else if (lts_pkg::is_single(ch))
                    begin
                        res0.start  = pos_reg[lts_pkg::START_W-1:0];
                        res0.length = 17'd1;
                        res0.last   = 1'b1;
                        res_count   = 2'd1;
                    end
                    else if (ch == lts_pkg::CH_DQUOTE)
                    begin
                        begin_next = pos_reg[lts_pkg::START_W-1:0];
                        mode_next  = lts_pkg::MODE_STRING;
                    end
                    else if (ch == lts_pkg::CH_SEMICOLON)
                    begin
                        mode_next = lts_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        begin_next = pos_reg[lts_pkg::START_W-1:0];
                        mode_next  = lts_pkg::MODE_SYMBOL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= lts_pkg::MODE_IDLE;
            begin_reg <= '0;
            pos_reg   <= '0;
        end
        else if (in_take)
        begin
            mode_reg  <= mode_next;
            begin_reg <= begin_next;
            pos_reg   <= pos_next;
        end
    end

    // result queue storage: up to two records written per beat
    always_ff @(posedge clk)
    begin
        if (in_take && res_count != 2'd0)
            queue_mem[wr_ptr_reg] <= res0;
        if (in_take && res_count == 2'd2)
            queue_mem[wr_ptr_reg + QPTR_W'(1)] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_take)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(res_count);
            if (out_take)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_reg + (in_take ? QCNT_W'(res_count) : '0)
                         - QCNT_W'(out_take);
        end
    end

    assign token_start         = queue_mem[rd_ptr_reg].start;
    assign token_length        = queue_mem[rd_ptr_reg].length;
    assign end_token           = queue_mem[rd_ptr_reg].end_tok;
    assign unterminated_string = queue_mem[rd_ptr_reg].unterm;
    assign last_result         = queue_mem[rd_ptr_reg].last;

endmodule

/* hw/rtl/lts_checker.sv */
// ----------------------------------------------------------------------------
// lts_checker: port-level checks for the token scanner
// Watches the output channel for stall behaviour and record consistency.
// ----------------------------------------------------------------------------
module lts_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [lts_pkg::START_W-1:0]  token_start,
    input logic [lts_pkg::LEN_W-1:0]    token_length,
    input logic                         end_token,
    input logic                         unterminated_string,
    input logic                         last_result
);

    // a stalled beat stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat withdrawn under stall");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_token |-> last_result)
        else $error("end token not marked as last record");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_token |-> token_start == '0 && token_length == '0)
        else $error("end token carries offset or length");

    a_token_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !end_token |-> !unterminated_string && token_length != '0)
        else $error("ordinary token malformed");

endmodule

bind lisp_token_scanner_top lts_checker u_lts_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .token_start         (token_start),
    .token_length        (token_length),
    .end_token           (end_token),
    .unterminated_string (unterminated_string),
    .last_result         (last_result)
);

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the s-expression token scanner
// Feeds source texts one character per beat, each closed by an end beat.
// Every accepted beat runs through a local scanner model that queues the
// token records it should give; every record taken from the output is
// compared field by field with the oldest one queued. The input idles and
// the output stalls at random; one phase holds it off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned TEXT_LIMIT =
        (lts_pkg::MAX_TEXT_DEFAULT < 65536) ? lts_pkg::MAX_TEXT_DEFAULT : 65536;
    localparam int          CYCLE_LIMIT = 800000;
    localparam int          MAX_GAP     = 18;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [7:0]                   ch = 8'h00;
    logic                         end_of_text = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [lts_pkg::START_W-1:0]  token_start;
    logic [lts_pkg::LEN_W-1:0]    token_length;
    logic                         end_token;
    logic                         unterminated_string;
    logic                         last_result;

    // scanner model state
    lts_pkg::scan_mode_t          sc_mode = lts_pkg::MODE_IDLE;
    logic [15:0]                  sc_begin = '0;
    logic [16:0]                  sc_pos = '0;
    lts_pkg::token_t              exp_tokens[$];

    logic [7:0]          text_q[$];
    bit                  tx_idle = 1'b1;
    bit                  rx_idle = 1'b1;
    int                  holdoff_req = 0;
    logic                holding = 1'b0;
    int                  rx_wait = 0;
    int                  errors = 0;
    int                  beats_sent = 0;
    int                  texts_sent = 0;
    int                  tokens_checked = 0;
    int                  cycles = 0;

    lisp_token_scanner_top uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .ch                  (ch),
        .end_of_text         (end_of_text),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .token_start         (token_start),
        .token_length        (token_length),
        .end_token           (end_token),
        .unterminated_string (unterminated_string),
        .last_result         (last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d records outstanding",
                     cycles, exp_tokens.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic bit blank_char(input logic [7:0] c);
        case (c) inside
            lts_pkg::CH_SPACE, lts_pkg::CH_TAB, lts_pkg::CH_NEWLINE,
            lts_pkg::CH_VTAB, lts_pkg::CH_FORMFEED, lts_pkg::CH_RETURN,
            lts_pkg::CH_COMMA: return 1'b1;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic bit lone_char(input logic [7:0] c);
        case (c) inside
            lts_pkg::CH_LBRACKET, lts_pkg::CH_RBRACKET, lts_pkg::CH_LBRACE,
            lts_pkg::CH_RBRACE, lts_pkg::CH_LPAREN, lts_pkg::CH_RPAREN,
            lts_pkg::CH_APOS, lts_pkg::CH_BACKTICK, lts_pkg::CH_CARET,
            lts_pkg::CH_AT: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic lts_pkg::token_t make_token(input logic [15:0] s,
                                                   input logic [16:0] l,
                                                   input logic e, input logic u);
        lts_pkg::token_t t;
        t.start   = s;
        t.length  = l;
        t.end_tok = e;
        t.unterm  = u;
        t.last    = 1'b0;
        return t;
    endfunction

    // Advance the model by one accepted beat and queue the records it gives.
    task automatic predict_tokens(input logic [7:0] c, input logic eot);
        lts_pkg::token_t recs[$];
        logic            unterm;
        unterm = 1'b0;
        if (eot)
        begin
            if (sc_mode == lts_pkg::MODE_SYMBOL)
                recs.push_back(make_token(sc_begin, sc_pos - {1'b0, sc_begin}, 1'b0, 1'b0));
            unterm = (sc_mode == lts_pkg::MODE_STRING) ||
                     (sc_mode == lts_pkg::MODE_ESCAPE);
            recs.push_back(make_token('0, '0, 1'b1, unterm));
            sc_mode  = lts_pkg::MODE_IDLE;
            sc_begin = '0;
            sc_pos   = '0;
        end
        else if (sc_pos < TEXT_LIMIT)
        begin
            case (sc_mode)
                lts_pkg::MODE_SYMBOL:
                begin
                    if (blank_char(c) || lone_char(c))
                    begin
                        recs.push_back(make_token(sc_begin, sc_pos - {1'b0, sc_begin},
                                                  1'b0, 1'b0));
                        if (lone_char(c))
                            recs.push_back(make_token(sc_pos[15:0], 17'd1, 1'b0, 1'b0));
                        sc_mode = lts_pkg::MODE_IDLE;
                    end
                end
                lts_pkg::MODE_STRING:
                begin
                    if (c == lts_pkg::CH_BACKSLASH)
                        sc_mode = lts_pkg::MODE_ESCAPE;
                    else if (c == lts_pkg::CH_DQUOTE)
                    begin
                        recs.push_back(make_token(sc_begin,
                                                  sc_pos + 17'd1 - {1'b0, sc_begin},
                                                  1'b0, 1'b0));
                        sc_mode = lts_pkg::MODE_IDLE;
                    end
                end
                lts_pkg::MODE_ESCAPE:
                    sc_mode = lts_pkg::MODE_STRING;
                lts_pkg::MODE_COMMENT:
                begin
                    if (c == lts_pkg::CH_NEWLINE)
                        sc_mode = lts_pkg::MODE_IDLE;
                end
                default:
                begin
                    sc_mode = lts_pkg::MODE_IDLE;
                    if (blank_char(c))
                        sc_mode = lts_pkg::MODE_IDLE;
                    else if (lone_char(c))
                        recs.push_back(make_token(sc_pos[15:0], 17'd1, 1'b0, 1'b0));
                    else if (c == lts_pkg::CH_DQUOTE)
                    begin
                        sc_begin = sc_pos[15:0];
                        sc_mode  = lts_pkg::MODE_STRING;
                    end
                    else if (c == lts_pkg::CH_SEMICOLON)
                        sc_mode = lts_pkg::MODE_COMMENT;
                    else
                    begin
                        sc_begin = sc_pos[15:0];
                        sc_mode  = lts_pkg::MODE_SYMBOL;
                    end
                end
            endcase
            sc_pos = sc_pos + 17'd1;
        end
        if (recs.size() > 0)
            recs[recs.size()-1].last = 1'b1;
        foreach (recs[i])
            exp_tokens.push_back(recs[i]);
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("%0t: mismatch: %s", $time, what);
    endtask

    // Check each taken record, then draw how long to stall before the next.
    always @(posedge clk)
    begin : token_check
        lts_pkg::token_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            tokens_checked++;
            if (exp_tokens.size() == 0)
                report_mismatch($sformatf("record %0d with nothing expected (start %0d)",
                                          tokens_checked, token_start));
            else
            begin
                want = exp_tokens.pop_front();
                if (token_start !== want.start)
                    report_mismatch($sformatf("record %0d start %0d, want %0d",
                                              tokens_checked, token_start, want.start));
                if (token_length !== want.length)
                    report_mismatch($sformatf("record %0d length %0d, want %0d",
                                              tokens_checked, token_length, want.length));
                if (end_token !== want.end_tok)
                    report_mismatch($sformatf("record %0d end flag %b, want %b",
                                              tokens_checked, end_token, want.end_tok));
                if (unterminated_string !== want.unterm)
                    report_mismatch($sformatf("record %0d unterminated %b, want %b",
                                              tokens_checked, unterminated_string,
                                              want.unterm));
                if (last_result !== want.last)
                    report_mismatch($sformatf("record %0d last %b, want %b",
                                              tokens_checked, last_result, want.last));
            end
            rx_wait = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
        else if (rx_wait > 0)
            rx_wait--;
        out_stall <= rst_n && ((rx_wait > 0) || holding);
    end

    // Long hold-off of the output, counted here so the sender keeps offering.
    always
    begin
        @(posedge clk);
        if (holdoff_req > 0)
        begin
            holding <= 1'b1;
            repeat (holdoff_req) @(posedge clk);
            holding <= 1'b0;
            holdoff_req = 0;
        end
    end

    task automatic send_item(input logic [7:0] c, input logic eot);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        ch          <= eot ? 8'($urandom_range(0, 255)) : c;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        beats_sent++;
        predict_tokens(c, eot);
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_item(text_q[i], 1'b0);
        send_item(8'h00, 1'b1);
        texts_sent++;
        text_q.delete();
    endtask

    // Hold the input until every queued record has been taken.
    task automatic wait_for_tokens();
        in_valid <= 1'b0;
        while (exp_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_lone();
        case ($urandom_range(0, 9))
            0:       return lts_pkg::CH_LBRACKET;
            1:       return lts_pkg::CH_RBRACKET;
            2:       return lts_pkg::CH_LBRACE;
            3:       return lts_pkg::CH_RBRACE;
            4:       return lts_pkg::CH_LPAREN;
            5:       return lts_pkg::CH_RPAREN;
            6:       return lts_pkg::CH_APOS;
            7:       return lts_pkg::CH_BACKTICK;
            8:       return lts_pkg::CH_CARET;
            default: return lts_pkg::CH_AT;
        endcase
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 6))
            0:       return lts_pkg::CH_SPACE;
            1:       return lts_pkg::CH_TAB;
            2:       return lts_pkg::CH_NEWLINE;
            3:       return lts_pkg::CH_VTAB;
            4:       return lts_pkg::CH_FORMFEED;
            5:       return lts_pkg::CH_RETURN;
            default: return lts_pkg::CH_COMMA;
        endcase
    endfunction

    // Any byte that keeps a symbol open; a first character must also not
    // open a string or a comment.
    function automatic logic [7:0] pick_sym(input bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (blank_char(c) || lone_char(c) ||
               (first && (c == lts_pkg::CH_DQUOTE || c == lts_pkg::CH_SEMICOLON)));
        return c;
    endfunction

    function automatic logic [7:0] pick_tricky();
        case ($urandom_range(0, 5))
            0:       return lts_pkg::CH_DQUOTE;
            1:       return lts_pkg::CH_BACKSLASH;
            2:       return lts_pkg::CH_SEMICOLON;
            3:       return pick_lone();
            4:       return pick_blank();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Build a mostly well-formed text; some end inside a token, some are noise.
    task automatic gen_lisp_text();
        int         parts;
        int         n;
        logic [7:0] c;
        text_q.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 20);
            repeat (n) text_q.push_back(pick_tricky());
            return;
        end
        parts = $urandom_range(1, 10);
        repeat (parts)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    text_q.push_back(pick_sym(1'b1));
                    n = $urandom_range(0, 5);
                    repeat (n) text_q.push_back(pick_sym(1'b0));
                end
                1:
                begin
                    text_q.push_back(lts_pkg::CH_DQUOTE);
                    n = $urandom_range(0, 5);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            text_q.push_back(lts_pkg::CH_BACKSLASH);
                            text_q.push_back(pick_tricky());
                        end
                        else
                        begin
                            do
                                c = pick_tricky();
                            while (c == lts_pkg::CH_DQUOTE || c == lts_pkg::CH_BACKSLASH);
                            text_q.push_back(c);
                        end
                    end
                    text_q.push_back(lts_pkg::CH_DQUOTE);
                end
                2:
                begin
                    text_q.push_back(lts_pkg::CH_SEMICOLON);
                    n = $urandom_range(0, 5);
                    repeat (n)
                    begin
                        do
                            c = pick_tricky();
                        while (c == lts_pkg::CH_NEWLINE);
                        text_q.push_back(c);
                    end
                    text_q.push_back(lts_pkg::CH_NEWLINE);
                end
                3:
                    text_q.push_back(pick_lone());
                default:
                    text_q.push_back(pick_blank());
            endcase
            if ($urandom_range(0, 1) == 0)
                text_q.push_back(pick_blank());
        end
        // leave the text open inside a string, an escape, a comment or a symbol
        case ($urandom_range(0, 7))
            0: add_str("\"ab");
            1: add_str("\"q\\");
            2: add_str(";zz");
            3: text_q.push_back(pick_sym(1'b1));
            default: ;
        endcase
    endtask

    task automatic test_directed();
        // symbol with a quote and semicolon inside, tab, symbol ended by ')'
        add_str("(a\";\tb)");
        send_text();
        // zero and all-ones bytes, escaped quote in a string, comment to newline
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        add_str(",\"\\\"\";c\n@");
        send_text();
        // end while an escape is pending
        add_str("\"x\\");
        send_text();
        // end inside a comment
        add_str(";");
        send_text();
        wait_for_tokens();
    endtask

    task automatic test_random_texts(input int beats);
        int target;
        target = beats_sent + beats;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        while (beats_sent < target)
        begin
            gen_lisp_text();
            send_text();
            if ($urandom_range(0, 9) == 0)
                wait_for_tokens();
        end
        wait_for_tokens();
    endtask

    task automatic test_back_to_back(input int beats);
        int target;
        target = beats_sent + beats;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        while (beats_sent < target)
        begin
            gen_lisp_text();
            send_text();
        end
        wait_for_tokens();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_output_holdoff();
        tx_idle = 1'b0;
        holdoff_req = 300;
        repeat (30) add_str("(ab)");
        send_text();
        wait_for_tokens();
        while (holdoff_req != 0)
            @(posedge clk);
        tx_idle = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_texts(950);
        test_back_to_back(250);
        test_output_holdoff();
        in_valid <= 1'b0;
        while (exp_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("ran %0d texts in %0d input beats, %0d token records checked",
                 texts_sent, beats_sent, tokens_checked);
        $display("directed, random, back-to-back and long output hold-off phases");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
